@@ rtl/i2cm_pkg.sv @@
package i2cm_pkg;

	localparam int BYTE_BITS = 8;
	localparam int BIT_POS_W = 4;
	localparam int FIFO_DEPTH = 2;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_RELEASE = 3'd1,
		CMD_START   = 3'd2,
		CMD_STOP    = 3'd3,
		CMD_WRITE   = 3'd4,
		CMD_READ    = 3'd5,
		CMD_ACK     = 3'd6,
		CMD_NACK    = 3'd7
	} cmd_t;

	typedef struct packed {
		cmd_t                 command;
		logic [BYTE_BITS-1:0] write_data;
		logic                 sda_in;
	} in_item_t;

	typedef struct packed {
		logic                 scl_level;
		logic                 sda_level;
		logic                 busy_res;
		logic                 done_res;
		logic [BYTE_BITS-1:0] read_data;
		logic                 slave_ack;
	} out_item_t;

	// tick as held in the queue between front and back
	typedef struct packed {
		logic                 has_cmd;
		logic                 is_write;
		cmd_t                 command;
		logic [BYTE_BITS-1:0] write_data;
		logic                 sda_in;
	} tick_t;

	// handshake between front queue and back engine
	typedef struct packed {
		logic  valid;
		tick_t tick;
	} front_out_t;

endpackage

@@ rtl/i2cm_front.sv @@
module i2cm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  i2cm_pkg::in_item_t item,
	output i2cm_pkg::front_out_t fo,
	input  logic               take
);
	import i2cm_pkg::*;

	tick_t      mem_q [FIFO_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	tick_t      tick_in;
	logic       do_push;
	logic       do_pop;

	// classify on entry
	always_comb begin
		tick_in.has_cmd    = (item.command != CMD_NONE);
		tick_in.is_write   = (item.command == CMD_WRITE);
		tick_in.command    = item.command;
		tick_in.write_data = item.write_data;
		tick_in.sda_in     = item.sda_in;
	end

	assign full     = (count_q == 2'(FIFO_DEPTH));
	assign do_push  = push && !full;
	assign fo.valid = (count_q != 2'd0);
	assign fo.tick  = mem_q[rd_ptr_q];
	assign do_pop   = take && fo.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= tick_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/i2cm_back.sv @@
module i2cm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2cm_pkg::front_out_t fo,
	output logic                 take,
	output logic                 empty,
	input  logic                 pop,
	output i2cm_pkg::out_item_t  result
);
	import i2cm_pkg::*;

	// engine state
	cmd_t                 act_q;
	logic [BIT_POS_W-1:0] bp_q;
	logic                 hp_q;
	logic [BYTE_BITS-1:0] sh_q;
	logic                 clk_line_q;
	logic                 dat_line_q;
	logic                 ack_q;
	logic [BYTE_BITS-1:0] rx_q;

	// next engine state
	cmd_t                 act_d;
	logic [BIT_POS_W-1:0] bp_d;
	logic                 hp_d;
	logic [BYTE_BITS-1:0] sh_d;
	logic                 clk_line_d;
	logic                 dat_line_d;
	logic                 ack_d;
	logic [BYTE_BITS-1:0] rx_d;
	out_item_t            res_d;
	logic                 scl_o;
	logic                 sda_o;
	logic                 done;

	// result queue
	out_item_t  mem_q [FIFO_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       room;
	logic       do_pop;

	assign do_pop = pop && !empty;
	assign room   = (count_q != 2'(FIFO_DEPTH)) || do_pop;
	assign take   = fo.valid && room;
	assign empty  = (count_q == 2'd0);
	assign result = mem_q[rd_ptr_q];

	always_comb begin
		act_d = act_q;
		bp_d  = bp_q;
		hp_d  = hp_q;
		sh_d  = sh_q;
		ack_d = ack_q;
		rx_d  = rx_q;
		scl_o = clk_line_q;
		sda_o = dat_line_q;
		done  = 1'b0;

		// latch a new command only while idle
		if (act_q == CMD_NONE && fo.tick.has_cmd) begin
			act_d = fo.tick.command;
			bp_d  = '0;
			hp_d  = 1'b0;
			sh_d  = fo.tick.is_write ? fo.tick.write_data : '0;
		end

		if (act_d != CMD_NONE) begin
			case (act_d)
				CMD_RELEASE: begin
					scl_o = 1'b1;
					sda_o = 1'b1;
					done  = 1'b1;
				end
				CMD_START: begin
					scl_o = 1'b1;
					if (bp_d == '0) begin
						sda_o = 1'b1;
						bp_d  = BIT_POS_W'(1);
					end else begin
						sda_o = 1'b0;
						done  = 1'b1;
					end
				end
				CMD_STOP: begin
					scl_o = 1'b1;
					if (bp_d == '0) begin
						sda_o = 1'b0;
						bp_d  = BIT_POS_W'(1);
					end else begin
						sda_o = 1'b1;
						done  = 1'b1;
					end
				end
				CMD_WRITE: begin
					if (bp_d < BIT_POS_W'(BYTE_BITS)) begin
						sda_o = sh_d[BYTE_BITS-1];
						scl_o = hp_d;
						if (hp_d) begin
							hp_d = 1'b0;
							sh_d = {sh_d[BYTE_BITS-2:0], 1'b0};
							bp_d = bp_d + BIT_POS_W'(1);
						end else begin
							hp_d = 1'b1;
						end
					end else if (bp_d == BIT_POS_W'(BYTE_BITS)) begin
						sda_o = 1'b1;
						scl_o = hp_d;
						if (hp_d) begin
							// slave acknowledges by pulling SDA low
							ack_d = ~fo.tick.sda_in;
							hp_d  = 1'b0;
							bp_d  = bp_d + BIT_POS_W'(1);
						end else begin
							hp_d = 1'b1;
						end
					end else begin
						scl_o = 1'b0;
						sda_o = 1'b1;
						done  = 1'b1;
					end
				end
				CMD_READ: begin
					sda_o = 1'b1;
					if (bp_d < BIT_POS_W'(BYTE_BITS)) begin
						scl_o = hp_d;
						if (hp_d) begin
							sh_d = {sh_d[BYTE_BITS-2:0], fo.tick.sda_in};
							hp_d = 1'b0;
							bp_d = bp_d + BIT_POS_W'(1);
						end else begin
							hp_d = 1'b1;
						end
					end else begin
						scl_o = 1'b0;
						rx_d  = sh_d;
						done  = 1'b1;
					end
				end
				default: begin
					// ack or nack
					sda_o = (act_d == CMD_ACK) ? 1'b0 : 1'b1;
					if (bp_d == '0) begin
						scl_o = 1'b0;
						bp_d  = BIT_POS_W'(1);
					end else if (bp_d == BIT_POS_W'(1)) begin
						scl_o = 1'b1;
						bp_d  = BIT_POS_W'(2);
					end else begin
						scl_o = 1'b0;
						done  = 1'b1;
					end
				end
			endcase
		end

		clk_line_d = scl_o;
		dat_line_d = sda_o;
		if (done) begin
			// hold SCL low after a start condition
			if (act_d == CMD_START) begin
				clk_line_d = 1'b0;
			end
			act_d = CMD_NONE;
			bp_d  = '0;
			hp_d  = 1'b0;
		end

		res_d.scl_level = scl_o;
		res_d.sda_level = sda_o;
		res_d.busy_res  = (act_q != CMD_NONE) || fo.tick.has_cmd;
		res_d.done_res  = done;
		res_d.read_data = rx_d;
		res_d.slave_ack = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q      <= CMD_NONE;
			bp_q       <= '0;
			hp_q       <= 1'b0;
			sh_q       <= '0;
			clk_line_q <= 1'b1;
			dat_line_q <= 1'b1;
			ack_q      <= 1'b0;
			rx_q       <= '0;
		end else if (take) begin
			act_q      <= act_d;
			bp_q       <= bp_d;
			hp_q       <= hp_d;
			sh_q       <= sh_d;
			clk_line_q <= clk_line_d;
			dat_line_q <= dat_line_d;
			ack_q      <= ack_d;
			rx_q       <= rx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mem_q[wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (take) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({take, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/i2c_master_bit_engine_unit.sv @@
// An item pushed into the front queue passes to the engine step, which writes its result
//   into the result queue for popping; the step waits while that queue is full.
// Throughput: one item per cycle while the result queue has room, set by the engine step.
// Reset (arst_n low, asynchronous): both queues empty, engine idle, SCL and SDA released,
//   read byte and acknowledge flag cleared.
module i2c_master_bit_engine_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  i2cm_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output i2cm_pkg::out_item_t result
);
	import i2cm_pkg::*;

	// front to back: head of the tick queue and its take strobe
	front_out_t fo;
	logic       take;

	// Front: accept ticks, flag command and write, hold them in a short queue so the
	// input side keeps flowing while the result side stalls, until the queue fills.
	i2cm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.fo     (fo),
		.take   (take)
	);

	// Back: advance the bus sequencer by one tick per queued item and drop each
	// tick's result into the result queue. Commands arriving while a sequence runs
	// are dropped; the running sequence carries on.
	i2cm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.fo     (fo),
		.take   (take),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
